### rtl/core/fds_pkg.sv
// ----------------------------------------------------------------------------
// fds_pkg
// Types, constants and the power-of-ten table shared by the float to
// decimal split pipeline.
// ----------------------------------------------------------------------------
package fds_pkg;

    localparam int BITS_W     = 32;
    localparam int DIG_W      = 4;
    localparam int MANT_W     = 24;
    localparam int EXP_W      = 8;
    localparam int SHIFT_W    = 6;
    localparam int SCALE_W    = 30;
    localparam int PROD_W     = MANT_W + SCALE_W;
    localparam int INT_W      = 31;
    localparam int FRAC_OUT_W = 30;

    localparam logic [EXP_W-1:0] EXP_INVALID = 8'd158;
    localparam logic [EXP_W-1:0] EXP_WHOLE   = 8'd150;
    localparam logic [EXP_W-1:0] SHIFT_SPLIT = 8'd24;
    localparam logic [EXP_W-1:0] SHIFT_LIMIT = 8'd56;

    typedef logic [BITS_W-1:0]     t_bits;
    typedef logic [DIG_W-1:0]      t_digits;
    typedef logic [INT_W-1:0]      t_int;
    typedef logic [FRAC_OUT_W-1:0] t_frac;
    typedef logic [SCALE_W-1:0]    t_scale;

    typedef struct packed {
        logic                sign;
        logic                inv;
        t_int                ipart;
        logic [MANT_W-1:0]   frac;
        logic [SHIFT_W-1:0]  shift;
        t_scale              scale;
    } t_dec;

    typedef struct packed {
        logic                sign;
        logic                inv;
        t_int                ipart;
        logic [PROD_W-1:0]   prod;
        logic [SHIFT_W-1:0]  shift;
        t_scale              scale;
    } t_prod;

    typedef struct packed {
        logic   sign;
        logic   inv;
        t_int   ipart;
        t_frac  fpart;
        t_scale scale;
    } t_rnd;

    typedef struct packed {
        logic  sign;
        t_int  ipart;
        t_frac fpart;
        logic  inv;
    } t_res;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
    } t_stage_en;

    function automatic t_scale f_pow10(input t_digits d);
        t_scale p;
        unique case (d)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

### rtl/core/fds_if.sv
// ----------------------------------------------------------------------------
// fds_if
// Request and result channels of the float to decimal split core.
// ----------------------------------------------------------------------------
interface fds_in_if;
    logic               valid;
    logic               ready;
    fds_pkg::t_bits     float_bits;
    fds_pkg::t_digits   digit_count;

    modport source (output valid, output float_bits, output digit_count, input ready);
    modport sink   (input valid, input float_bits, input digit_count, output ready);
endinterface

interface fds_out_if;
    logic               valid;
    logic               ready;
    logic               sign_negative;
    fds_pkg::t_int      integer_part;
    fds_pkg::t_frac     fraction_value;
    logic               invalid;

    modport source (output valid, output sign_negative, output integer_part,
                    output fraction_value, output invalid, input ready);
    modport sink   (input valid, input sign_negative, input integer_part,
                    input fraction_value, input invalid, output ready);
endinterface

### rtl/core/fds_decode.sv
// ----------------------------------------------------------------------------
// fds_decode
// Stage 1: unpack the float, clamp the digit count, split the magnitude
// into integer part and binary fraction, and pick the scale.
// ----------------------------------------------------------------------------
module fds_decode #(
    parameter int MAX_DIGITS = 9
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  fds_pkg::t_bits   i_float_bits,
    input  fds_pkg::t_digits i_digit_count,
    output fds_pkg::t_dec    o_dec
);
    import fds_pkg::*;

    logic [EXP_W-1:0]  expo;
    logic [MANT_W-1:0] mant;
    logic [EXP_W-1:0]  shift_full;
    t_digits           digits;
    t_dec              n_dec;
    t_dec              r_dec;

    always_comb begin
        expo       = i_float_bits[30:23];
        mant       = {(expo != '0), i_float_bits[22:0]};
        shift_full = EXP_WHOLE - expo;
        digits     = (i_digit_count > DIG_W'(MAX_DIGITS)) ? DIG_W'(MAX_DIGITS)
                                                          : i_digit_count;
        n_dec       = '0;
        n_dec.shift = SHIFT_W'(1);
        n_dec.scale = f_pow10(digits);
        priority if (expo >= EXP_INVALID) begin
            n_dec.inv = 1'b1;
        end else if (expo >= EXP_WHOLE) begin
            n_dec.sign  = i_float_bits[31];
            n_dec.ipart = INT_W'(mant) << 3'(expo - EXP_WHOLE);
        end else if (expo == '0) begin
            n_dec.sign = i_float_bits[31] && (i_float_bits[22:0] != '0);
        end else begin
            n_dec.sign = i_float_bits[31];
            if (shift_full < SHIFT_SPLIT) begin
                n_dec.ipart = INT_W'(mant >> shift_full[4:0]);
                n_dec.frac  = mant & ((MANT_W'(1) << shift_full[4:0]) - MANT_W'(1));
                n_dec.shift = shift_full[SHIFT_W-1:0];
            end else if (shift_full < SHIFT_LIMIT) begin
                n_dec.frac  = mant;
                n_dec.shift = shift_full[SHIFT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dec <= n_dec;
        end
    end

    assign o_dec = r_dec;

endmodule

### rtl/core/fds_scale.sv
// ----------------------------------------------------------------------------
// fds_scale
// Stages 2 and 3: multiply the binary fraction by the power of ten, then
// add one half and shift the binary point away.
// ----------------------------------------------------------------------------
module fds_scale (
    input  logic          i_clk,
    input  logic          i_en_mul,
    input  logic          i_en_rnd,
    input  fds_pkg::t_dec i_dec,
    output fds_pkg::t_rnd o_rnd
);
    import fds_pkg::*;

    t_prod             n_prod;
    t_prod             r_prod;
    t_rnd              n_rnd;
    t_rnd              r_rnd;
    logic [PROD_W:0]   sum;
    logic [PROD_W:0]   rnd;

    always_comb begin
        n_prod.sign  = i_dec.sign;
        n_prod.inv   = i_dec.inv;
        n_prod.ipart = i_dec.ipart;
        n_prod.prod  = PROD_W'(i_dec.frac) * PROD_W'(i_dec.scale);
        n_prod.shift = i_dec.shift;
        n_prod.scale = i_dec.scale;
    end

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_prod <= n_prod;
        end
    end

    always_comb begin
        sum = {1'b0, r_prod.prod} + ((PROD_W+1)'(1) << (r_prod.shift - SHIFT_W'(1)));
        rnd = sum >> r_prod.shift;
        n_rnd.sign  = r_prod.sign;
        n_rnd.inv   = r_prod.inv;
        n_rnd.ipart = r_prod.ipart;
        n_rnd.fpart = rnd[FRAC_OUT_W-1:0];
        n_rnd.scale = r_prod.scale;
    end

    always_ff @(posedge i_clk) begin
        if (i_en_rnd) begin
            r_rnd <= n_rnd;
        end
    end

    assign o_rnd = r_rnd;

endmodule

### rtl/core/fds_carry.sv
// ----------------------------------------------------------------------------
// fds_carry
// Stage 4: wrap a fraction that rounded up to the scale and carry into the
// integer part; holds the result register.
// ----------------------------------------------------------------------------
module fds_carry (
    input  logic          i_clk,
    input  logic          i_en,
    input  fds_pkg::t_rnd i_rnd,
    output fds_pkg::t_res o_res
);
    import fds_pkg::*;

    t_res n_res;
    t_res r_res;

    always_comb begin
        n_res.sign = i_rnd.sign;
        n_res.inv  = i_rnd.inv;
        if (SCALE_W'(i_rnd.fpart) >= i_rnd.scale) begin
            n_res.fpart = '0;
            n_res.ipart = i_rnd.ipart + INT_W'(1);
        end else begin
            n_res.fpart = i_rnd.fpart;
            n_res.ipart = i_rnd.ipart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

### rtl/core/float_decimal_split_core.sv
// ----------------------------------------------------------------------------
// float_decimal_split_core
// Splits a single-precision float into sign, integer part and a rounded
// decimal fraction of up to MAX_DIGITS digits.
// ----------------------------------------------------------------------------
// Four-stage pipeline (decode, 24x30 multiply, round-and-shift, carry) that
// takes one request per clock unless stalls have filled it; each request
// passes the decode, product, round and result registers. The rate is set
// by the stage chain; the multiply stage is the deepest path. A stalled
// result register holds its value and the stages behind it keep filling, so
// up to four requests may be in flight. NaN, infinity and magnitudes of 2^31
// or more return invalid with zero parts; negative zero gives a positive sign.
module float_decimal_split_core #(
    parameter int MAX_DIGITS = 9
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fds_in_if.sink       i_req,
    fds_out_if.source    o_rsp
);
    import fds_pkg::*;

    logic [3:0] r_v;
    logic [3:0] n_v;
    t_stage_en  en;
    t_dec       dec;
    t_rnd       rnd;
    t_res       res;

    always_comb begin
        en.en4 = !r_v[3] || o_rsp.ready;
        en.en3 = !r_v[2] || en.en4;
        en.en2 = !r_v[1] || en.en3;
        en.en1 = !r_v[0] || en.en2;
        n_v[0] = en.en1 ? i_req.valid : r_v[0];
        n_v[1] = en.en2 ? r_v[0]      : r_v[1];
        n_v[2] = en.en3 ? r_v[1]      : r_v[2];
        n_v[3] = en.en4 ? r_v[2]      : r_v[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    fds_decode #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_decode (
        .i_clk         (i_clk),
        .i_en          (en.en1),
        .i_float_bits  (i_req.float_bits),
        .i_digit_count (i_req.digit_count),
        .o_dec         (dec)
    );

    fds_scale u_scale (
        .i_clk    (i_clk),
        .i_en_mul (en.en2),
        .i_en_rnd (en.en3),
        .i_dec    (dec),
        .o_rnd    (rnd)
    );

    fds_carry u_carry (
        .i_clk (i_clk),
        .i_en  (en.en4),
        .i_rnd (rnd),
        .o_res (res)
    );

    assign i_req.ready          = en.en1;
    assign o_rsp.valid          = r_v[3];
    assign o_rsp.sign_negative  = res.sign;
    assign o_rsp.integer_part   = res.ipart;
    assign o_rsp.fraction_value = res.fpart;
    assign o_rsp.invalid        = res.inv;

endmodule

### rtl/core/fds_chk.sv
// ----------------------------------------------------------------------------
// fds_chk
// Port-level checks on the float to decimal split core.
// ----------------------------------------------------------------------------
module fds_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_sign,
    input logic [30:0] i_int,
    input logic [29:0] i_frac,
    input logic        i_inv
);
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_comb begin
        n_cnt = r_cnt + 3'(in_acc) - 3'(out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_inv |-> !i_sign && (i_int == '0) && (i_frac == '0))
        else $error("invalid result with nonzero parts");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_frac < 30'd1000000000))
        else $error("fraction out of range");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_cnt != 3'd0))
        else $error("result without outstanding request");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("more requests in flight than stages");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_int) && $stable(i_frac))
        else $error("stalled result changed");

endmodule

bind float_decimal_split_core fds_chk u_fds_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_sign      (o_rsp.sign_negative),
    .i_int       (o_rsp.integer_part),
    .i_frac      (o_rsp.fraction_value),
    .i_inv       (o_rsp.invalid)
);
